// ===== rtl/rxq_pkg.sv =====
// shared types and constants for the range xor query engine
package rxq_pkg;

  localparam int XW    = 32;  // element and total width
  localparam int POS_W = 11;  // 1-based position field width

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // one result word from the sequencer
  typedef struct packed {
    logic          valid;
    logic [XW-1:0] xor_total;
    logic          range_error;
  } res_t;

endpackage

// ===== rtl/rxq_ram.sv =====
// single-port-write, registered-read memory
module rxq_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rxq_ctrl.sv =====
// sequencer: clearing pass, load read-modify-write and the range walk
module rxq_ctrl #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int BLOCK_SIZE   = 32,
  parameter int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
  parameter int BW = (((MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE) > 1) ?
                     $clog2((MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_func,
  input  logic [rxq_pkg::POS_W-1:0] in_position,
  input  logic [rxq_pkg::XW-1:0]    in_value,
  input  logic [rxq_pkg::POS_W-1:0] in_first,
  input  logic [rxq_pkg::POS_W-1:0] in_last,
  output logic                      elem_we,
  output logic [IW-1:0]             elem_waddr,
  output logic [rxq_pkg::XW-1:0]    elem_wdata,
  output logic [IW-1:0]             elem_raddr,
  input  logic [rxq_pkg::XW-1:0]    elem_rdata,
  output logic                      blk_we,
  output logic [BW-1:0]             blk_waddr,
  output logic [rxq_pkg::XW-1:0]    blk_wdata,
  output logic [BW-1:0]             blk_raddr,
  input  logic [rxq_pkg::XW-1:0]    blk_rdata,
  output rxq_pkg::res_t             res
);
  import rxq_pkg::*;

  localparam int LOG_BS = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 0;
  localparam int JW     = IW + 1;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LDWR  = 4'b0100,
    ST_WALK  = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  logic [IW-1:0]   clr_r, clr_nxt;
  logic [IW-1:0]   ld_idx_r, ld_idx_nxt;
  logic [XW-1:0]   value_r, value_nxt;
  logic [JW-1:0]   i_r, i_nxt;
  logic [IW-1:0]   hi_r, hi_nxt;
  logic [XW-1:0]   acc_r, acc_nxt;
  logic            pend_r, pend_nxt;
  logic            pend_blk_r, pend_blk_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [XW-1:0]   out_xor_r, out_xor_nxt;
  logic            out_err_r, out_err_nxt;

  logic            pos_ok, first_ok, last_ok;
  logic [POS_W-1:0] pos_m1, first_m1, last_m1;
  logic [IW-1:0]   in_idx;
  logic            in_walk, whole_blk;

  assign pos_ok   = (in_position != '0) && (32'(in_position) <= 32'(MAX_ELEMENTS));
  assign first_ok = (in_first != '0) && (32'(in_first) <= 32'(MAX_ELEMENTS));
  assign last_ok  = (in_last != '0) && (32'(in_last) <= 32'(MAX_ELEMENTS));
  assign pos_m1   = in_position - POS_W'(1);
  assign first_m1 = in_first - POS_W'(1);
  assign last_m1  = in_last - POS_W'(1);
  assign in_idx   = IW'(pos_m1);

  // walk step: whole block when aligned and the block fits below hi
  assign in_walk   = (i_r <= JW'(hi_r));
  assign whole_blk = ((i_r & JW'(BLOCK_SIZE - 1)) == '0) &&
                     ((32'(i_r) + 32'(BLOCK_SIZE) - 32'd1) <= 32'(hi_r));

  assign busy = (state_r != ST_IDLE);

  // read addresses: load address while idle, walk index while walking
  always_comb begin
    if (state_r == ST_WALK) begin
      elem_raddr = IW'(i_r);
      blk_raddr  = BW'(i_r >> LOG_BS);
    end else begin
      elem_raddr = in_idx;
      blk_raddr  = BW'(in_idx >> LOG_BS);
    end
  end

  // write ports: zeros during the clearing pass, load update in the write-back state
  always_comb begin
    elem_we    = 1'b0;
    blk_we     = 1'b0;
    elem_waddr = ld_idx_r;
    blk_waddr  = BW'(ld_idx_r >> LOG_BS);
    elem_wdata = value_r;
    blk_wdata  = blk_rdata ^ elem_rdata ^ value_r;
    if (state_r == ST_CLEAR) begin
      elem_we    = 1'b1;
      blk_we     = 1'b1;
      elem_waddr = clr_r;
      blk_waddr  = BW'(clr_r >> LOG_BS);
      elem_wdata = '0;
      blk_wdata  = '0;
    end else if (state_r == ST_LDWR) begin
      elem_we = 1'b1;
      blk_we  = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    ld_idx_nxt    = ld_idx_r;
    value_nxt     = value_r;
    i_nxt         = i_r;
    hi_nxt        = hi_r;
    acc_nxt       = acc_r;
    pend_nxt      = 1'b0;
    pend_blk_nxt  = pend_blk_r;
    out_valid_nxt = 1'b0;
    out_xor_nxt   = out_xor_r;
    out_err_nxt   = out_err_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + IW'(1);
        if (clr_r == IW'(MAX_ELEMENTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_func == FUNC_LOAD) begin
            if (pos_ok) begin
              ld_idx_nxt = in_idx;
              value_nxt  = in_value;
              state_nxt  = ST_LDWR;
            end
          end else if (!first_ok || !last_ok) begin
            out_valid_nxt = 1'b1;
            out_xor_nxt   = '0;
            out_err_nxt   = 1'b1;
          end else if (in_first > in_last) begin
            out_valid_nxt = 1'b1;
            out_xor_nxt   = '0;
            out_err_nxt   = 1'b0;
          end else begin
            i_nxt     = JW'(first_m1);
            hi_nxt    = IW'(last_m1);
            acc_nxt   = '0;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_LDWR: begin
        state_nxt = ST_IDLE;
      end
      ST_WALK: begin
        // fold in the word read on the previous step
        if (pend_r) begin
          acc_nxt = acc_r ^ (pend_blk_r ? blk_rdata : elem_rdata);
        end
        if (in_walk) begin
          pend_nxt     = 1'b1;
          pend_blk_nxt = whole_blk;
          i_nxt        = whole_blk ? (i_r + JW'(BLOCK_SIZE)) : (i_r + JW'(1));
        end else begin
          out_valid_nxt = 1'b1;
          out_xor_nxt   = acc_nxt;
          out_err_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ld_idx_r   <= ld_idx_nxt;
    value_r    <= value_nxt;
    i_r        <= i_nxt;
    hi_r       <= hi_nxt;
    acc_r      <= acc_nxt;
    pend_blk_r <= pend_blk_nxt;
    out_xor_r  <= out_xor_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign res.valid       = out_valid_r;
  assign res.xor_total   = out_xor_r;
  assign res.range_error = out_err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_xor_r == '0))
    else $error("range error word with nonzero total");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LDWR) |=> !out_valid_r)
    else $error("load produced a result word");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_WALK) |-> !pend_r)
    else $error("pending read outside the walk");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |=> !out_valid_r)
    else $error("result word during clearing pass");

endmodule

// ===== rtl/range_xor_query_engine_unit.sv =====
// top level of the range xor query engine
// query: N reads (partial-block elements plus whole-block totals, one per cycle) keep busy
//   high; the word is strobed once the last read is folded in, N is 92 worst case
// load: old element and block total read at acceptance, then busy during write-back;
//   a query outside the store or with first > last is strobed the cycle after acceptance
// a new query or load is accepted only while busy is low, after the previous one is done
// reset: synchronous, active low, then a clearing pass over every element with busy high;
//   result words are strobed on out_valid for one cycle and cannot be stalled
module range_xor_query_engine_unit #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int BLOCK_SIZE   = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_func,
  input  logic [rxq_pkg::POS_W-1:0] in_position,
  input  logic [rxq_pkg::XW-1:0]    in_value,
  input  logic [rxq_pkg::POS_W-1:0] in_first,
  input  logic [rxq_pkg::POS_W-1:0] in_last,
  output logic                      out_valid,
  output logic [rxq_pkg::XW-1:0]    out_xor_total,
  output logic                      out_range_error
);
  import rxq_pkg::*;

  // number of block totals, and address widths of the two memories
  localparam int BLOCK_COUNT = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int BW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

  // element store port signals
  logic          elem_we;
  logic [IW-1:0] elem_waddr, elem_raddr;
  logic [XW-1:0] elem_wdata, elem_rdata;

  // block total port signals
  logic          blk_we;
  logic [BW-1:0] blk_waddr, blk_raddr;
  logic [XW-1:0] blk_wdata, blk_rdata;

  res_t res;

  // sequencer: owns the walk index, accumulator and result register
  rxq_ctrl #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .BLOCK_SIZE  (BLOCK_SIZE),
    .IW          (IW),
    .BW          (BW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_func    (in_func),
    .in_position(in_position),
    .in_value   (in_value),
    .in_first   (in_first),
    .in_last    (in_last),
    .elem_we    (elem_we),
    .elem_waddr (elem_waddr),
    .elem_wdata (elem_wdata),
    .elem_raddr (elem_raddr),
    .elem_rdata (elem_rdata),
    .blk_we     (blk_we),
    .blk_waddr  (blk_waddr),
    .blk_wdata  (blk_wdata),
    .blk_raddr  (blk_raddr),
    .blk_rdata  (blk_rdata),
    .res        (res)
  );

  // element store, one word per position
  rxq_ram #(
    .DEPTH(MAX_ELEMENTS),
    .WIDTH(XW),
    .AW   (IW)
  ) u_elem_ram (
    .clk  (clk),
    .we   (elem_we),
    .waddr(elem_waddr),
    .wdata(elem_wdata),
    .raddr(elem_raddr),
    .rdata(elem_rdata)
  );

  // xor total of each block of elements
  rxq_ram #(
    .DEPTH(BLOCK_COUNT),
    .WIDTH(XW),
    .AW   (BW)
  ) u_blk_ram (
    .clk  (clk),
    .we   (blk_we),
    .waddr(blk_waddr),
    .wdata(blk_wdata),
    .raddr(blk_raddr),
    .rdata(blk_rdata)
  );

  assign out_valid       = res.valid;
  assign out_xor_total   = res.xor_total;
  assign out_range_error = res.range_error;

endmodule
